/* hdl/scu_pkg.sv */
// Package with opcodes, status codes and item types of the stack calculator.
package scu_pkg;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0,
    OP_POP  = 4'd1,
    OP_DUP  = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_MUL  = 4'd5,
    OP_DIV  = 4'd6,
    OP_SQRT = 4'd7,
    OP_HALT = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_NEGSQRT = 3'd4,
    ST_UNKNOWN = 3'd5,
    ST_HALTED  = 3'd6,
    ST_STOPPED = 3'd7
  } status_e;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic               value_valid;
    logic [2:0]         status;
  } out_item_t;

  // Classified command handed from the front part to the back part.
  typedef enum logic [3:0] {
    K_PUSH  = 4'd0,
    K_POP   = 4'd1,
    K_DUP   = 4'd2,
    K_ARITH = 4'd3,
    K_SQRT  = 4'd4,
    K_HALT  = 4'd5,
    K_UNK   = 4'd6
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         alu_op;  // 0 add, 1 sub, 2 mul, 3 div
    logic signed [31:0] value;
  } cmd_t;

  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_MUL = 2'd2;
  localparam logic [1:0] ALU_DIV = 2'd3;

endpackage

/* hdl/scu_ram.sv */
// Generic single-port RAM with registered read.
module scu_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* hdl/scu_front.sv */
// Front part: accepts input items, classifies them and queues the commands.
module scu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  scu_pkg::in_item_t  in_item_i,
  output logic               cmd_valid_o,
  input  logic               cmd_take_i,
  output scu_pkg::cmd_t      cmd_o
);
  scu_pkg::cmd_t cmd_n;
  scu_pkg::cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic       put, take;

  always_comb begin
    cmd_n.value  = in_item_i.push_value;
    cmd_n.alu_op = scu_pkg::ALU_ADD;
    case (in_item_i.opcode)
      scu_pkg::OP_PUSH: cmd_n.kind = scu_pkg::K_PUSH;
      scu_pkg::OP_POP:  cmd_n.kind = scu_pkg::K_POP;
      scu_pkg::OP_DUP:  cmd_n.kind = scu_pkg::K_DUP;
      scu_pkg::OP_ADD: begin
        cmd_n.kind = scu_pkg::K_ARITH;
        cmd_n.alu_op = scu_pkg::ALU_ADD;
      end
      scu_pkg::OP_SUB: begin
        cmd_n.kind = scu_pkg::K_ARITH;
        cmd_n.alu_op = scu_pkg::ALU_SUB;
      end
      scu_pkg::OP_MUL: begin
        cmd_n.kind = scu_pkg::K_ARITH;
        cmd_n.alu_op = scu_pkg::ALU_MUL;
      end
      scu_pkg::OP_DIV: begin
        cmd_n.kind = scu_pkg::K_ARITH;
        cmd_n.alu_op = scu_pkg::ALU_DIV;
      end
      scu_pkg::OP_SQRT: cmd_n.kind = scu_pkg::K_SQRT;
      scu_pkg::OP_HALT: cmd_n.kind = scu_pkg::K_HALT;
      default:          cmd_n.kind = scu_pkg::K_UNK;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign put         = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign take        = cmd_take_i && cmd_valid_o;
  assign cmd_o       = q_q[rd_q];

  always_comb begin
    wr_d  = put ? !wr_q : wr_q;
    rd_d  = take ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, put} - {1'b0, take};
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      q_q[wr_q] <= cmd_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
    end
  end
endmodule

/* hdl/scu_divsqrt.sv */
// Shared radix-2 unit for unsigned division and integer square root.
module scu_divsqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_sqrt_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);
  logic        busy_q, busy_d, sq_q;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] a_q, a_d, b_q, res_q, res_d;
  logic [33:0] rem_q, rem_d, trial;

  always_comb begin
    a_d   = a_q;
    rem_d = rem_q;
    res_d = res_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = '0;
    if (busy_q) begin
      if (sq_q) begin
        // Two bits of the radicand per step, one root bit out.
        rem_d = {rem_q[31:0], a_q[31:30]};
        trial = {res_q[31:0], 2'b01};
        a_d   = {a_q[29:0], 2'b00};
        if (rem_d >= trial) begin
          rem_d = rem_d - trial;
          res_d = {res_q[30:0], 1'b1};
        end else begin
          res_d = {res_q[30:0], 1'b0};
        end
      end else begin
        rem_d = {rem_q[32:0], a_q[31]};
        trial = {2'b00, b_q};
        a_d   = {a_q[30:0], 1'b0};
        if (rem_d >= trial) begin
          rem_d = rem_d - trial;
          res_d = {res_q[30:0], 1'b1};
        end else begin
          res_d = {res_q[30:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
    if (start_i) begin
      a_d    = a_i;
      rem_d  = '0;
      res_d  = '0;
      busy_d = 1'b1;
      cnt_d  = is_sqrt_i ? 6'd16 : 6'd32;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    rem_q <= rem_d;
    res_q <= res_d;
    if (start_i) begin
      b_q  <= b_i;
      sq_q <= is_sqrt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_o <= busy_q && (cnt_q == 6'd1);
    end
  end

  assign res_o = res_q;
endmodule

/* hdl/scu_back.sv */
// Back part: carries out commands on the operand stack and queues results.
module scu_back #(
  parameter int StackDepth = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_take_o,
  input  scu_pkg::cmd_t         cmd_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output scu_pkg::out_item_t    out_item_o
);
  localparam int AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int CW = $clog2(StackDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(StackDepth);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD1   = 7'b0000010,
    S_RD2   = 7'b0000100,
    S_CALC  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  scu_pkg::cmd_t cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic stop_q, stop_d;
  logic [31:0] y_q, y_d, x_q, x_d, r_q, r_d;
  logic qneg_q, qneg_d;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;
  logic ds_start, ds_sqrt, ds_done;
  logic [31:0] ds_a, ds_b, ds_res;
  logic [31:0] prod_q;
  logic res_valid_q, res_put;
  scu_pkg::out_item_t res_q, res_d;

  scu_ram #(.Width(32), .Depth(1 << AW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  scu_divsqrt u_ds (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ds_start),
    .is_sqrt_i(ds_sqrt),
    .a_i      (ds_a),
    .b_i      (ds_b),
    .done_o   (ds_done),
    .res_o    (ds_res)
  );

  assign empty_o    = !res_valid_q;
  assign out_item_o = res_q;

  always_ff @(posedge clk_i) begin
    prod_q <= x_q * y_q;
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    stop_d    = stop_q;
    y_d = y_q; x_d = x_q; r_d = r_q;
    qneg_d = qneg_q;
    ram_we    = 1'b0;
    ram_addr  = AW'(cnt_q - CW'(1));
    ram_wdata = r_q;
    ds_start  = 1'b0;
    ds_sqrt   = 1'b0;
    ds_a      = '0;
    ds_b      = '0;
    cmd_take_o = 1'b0;
    res_put   = 1'b0;
    res_d     = '{popped_value: '0, value_valid: 1'b0, status: scu_pkg::ST_OK};
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !res_valid_q) begin
          cmd_take_o = 1'b1;
          cmd_d = cmd_i;
          if (stop_q) begin
            res_put = 1'b1;
            res_d.status = scu_pkg::ST_STOPPED;
          end else begin
            case (cmd_i.kind)
              scu_pkg::K_PUSH: begin
                res_put = 1'b1;
                if (cnt_q >= DepthC) begin
                  res_d.status = scu_pkg::ST_FULL;
                  stop_d = 1'b1;
                end else begin
                  ram_we = 1'b1;
                  ram_addr = AW'(cnt_q);
                  ram_wdata = cmd_i.value;
                  cnt_d = cnt_q + CW'(1);
                end
              end
              scu_pkg::K_POP, scu_pkg::K_SQRT: begin
                if (cnt_q == '0) begin
                  res_put = 1'b1;
                  res_d.status = scu_pkg::ST_EMPTY;
                  stop_d = 1'b1;
                end else begin
                  state_d = S_RD1;
                end
              end
              scu_pkg::K_DUP: begin
                if (cnt_q == '0) begin
                  res_put = 1'b1;
                  res_d.status = scu_pkg::ST_EMPTY;
                  stop_d = 1'b1;
                end else if (cnt_q >= DepthC) begin
                  res_put = 1'b1;
                  res_d.status = scu_pkg::ST_FULL;
                  stop_d = 1'b1;
                end else begin
                  state_d = S_RD1;
                end
              end
              scu_pkg::K_ARITH: begin
                if (cnt_q < CW'(2)) begin
                  res_put = 1'b1;
                  res_d.status = scu_pkg::ST_EMPTY;
                  stop_d = 1'b1;
                end else begin
                  state_d = S_RD1;
                end
              end
              scu_pkg::K_HALT: begin
                res_put = 1'b1;
                res_d.status = scu_pkg::ST_HALTED;
                stop_d = 1'b1;
              end
              default: begin
                res_put = 1'b1;
                res_d.status = scu_pkg::ST_UNKNOWN;
              end
            endcase
          end
        end
      end
      S_RD1: begin
        // Top entry is being read; second one is addressed for arithmetic.
        ram_addr = AW'(cnt_q - CW'(2));
        state_d = (cmd_q.kind == scu_pkg::K_ARITH) ? S_RD2 : S_CALC;
        y_d = ram_rdata;
        if (cmd_q.kind != scu_pkg::K_ARITH) begin
          state_d = S_CALC;
        end
      end
      S_RD2: begin
        x_d = ram_rdata;
        state_d = S_CALC;
      end
      S_CALC: begin
        case (cmd_q.kind)
          scu_pkg::K_POP: begin
            res_put = 1'b1;
            res_d.popped_value = y_q;
            res_d.value_valid = 1'b1;
            cnt_d = cnt_q - CW'(1);
            state_d = S_IDLE;
          end
          scu_pkg::K_DUP: begin
            r_d = y_q;
            state_d = S_WRITE;
          end
          scu_pkg::K_SQRT: begin
            if (y_q[31]) begin
              res_put = 1'b1;
              res_d.status = scu_pkg::ST_NEGSQRT;
              stop_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              ds_start = 1'b1;
              ds_sqrt = 1'b1;
              ds_a = y_q;
              qneg_d = 1'b0;
              state_d = S_WAIT;
            end
          end
          default: begin
            case (cmd_q.alu_op)
              scu_pkg::ALU_ADD: begin
                r_d = x_q + y_q;
                state_d = S_WRITE;
              end
              scu_pkg::ALU_SUB: begin
                r_d = x_q - y_q;
                state_d = S_WRITE;
              end
              scu_pkg::ALU_MUL: state_d = S_MUL;
              default: begin
                if (y_q == '0) begin
                  res_put = 1'b1;
                  res_d.status = scu_pkg::ST_DIVZERO;
                  stop_d = 1'b1;
                  state_d = S_IDLE;
                end else begin
                  ds_start = 1'b1;
                  ds_a = x_q[31] ? 32'(-x_q) : x_q;
                  ds_b = y_q[31] ? 32'(-y_q) : y_q;
                  qneg_d = x_q[31] ^ y_q[31];
                  state_d = S_WAIT;
                end
              end
            endcase
          end
        endcase
      end
      S_MUL: begin
        r_d = prod_q;
        state_d = S_WRITE;
      end
      S_WAIT: begin
        if (ds_done) begin
          r_d = qneg_q ? 32'(-ds_res) : ds_res;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
        res_put = 1'b1;
        state_d = S_IDLE;
        case (cmd_q.kind)
          scu_pkg::K_DUP: begin
            ram_addr = AW'(cnt_q);
            cnt_d = cnt_q + CW'(1);
          end
          scu_pkg::K_ARITH: begin
            ram_addr = AW'(cnt_q - CW'(2));
            cnt_d = cnt_q - CW'(1);
          end
          default: ram_addr = AW'(cnt_q - CW'(1));
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    y_q    <= y_d;
    x_q    <= x_d;
    r_q    <= r_d;
    qneg_q <= qneg_d;
    if (res_put) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      stop_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      stop_q  <= stop_d;
      if (res_put) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end
endmodule

/* hdl/stack_calculator_unit.sv */
// Top level of the stack calculator.
// Items enter a two-entry command queue and are carried out one at a time
// against an operand stack held in a single-port RAM. Push, halt, unknown
// opcodes and faults found from the stack count are answered in the idle
// state; other commands read the stack and calculate, most writing back, with
// divide and square root done by the shared radix-2 divide and root unit,
// one bit per cycle. Each item yields one result held in an output register
// until popped; the next item starts once the result register is free.
module stack_calculator_unit #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  scu_pkg::in_item_t   in_item_i,
  output logic                empty,
  input  logic                pop,
  output scu_pkg::out_item_t  out_item_o
);
  logic          cmd_valid, cmd_take;
  scu_pkg::cmd_t cmd;

  scu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_take_i (cmd_take),
    .cmd_o      (cmd)
  );

  scu_back #(.StackDepth(STACK_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_take_o (cmd_take),
    .cmd_i      (cmd),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );
endmodule
